[rtl/core/heightfield_normal_stencil_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the height-field normal stencil
// Implication forms used at the end of the top-level stencil module.
// ----------------------------------------------------------------------------
`ifndef HEIGHTFIELD_NORMAL_STENCIL_UNIT_ASSERT_SVH
`define HEIGHTFIELD_NORMAL_STENCIL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HNS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("heightfield normal stencil: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HNS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("heightfield normal stencil: assertion failed");

`endif

[rtl/core/hns_pkg.sv]
// ----------------------------------------------------------------------------
// hns_pkg
// Types, widths and state encodings shared by the normal stencil modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hns_pkg;

	localparam int MAX_GRID_LOG2_DEF = 10;

	localparam int GRID_W     = 4;
	localparam int SCALE_W    = 16;
	localparam int HEIGHT_W   = 16;
	localparam int VIDX_W     = 21;
	localparam int COMP_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [GRID_W-1:0]  GRID_RESET  = 4'd8;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_LOG2    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 1'b1;

	// Scaled heights and their differences, in units of 2^-22.
	localparam int SCALED_W    = 32;
	localparam int DIFF_W      = 33;
	localparam int VEC_W       = 34;
	localparam int SUM_W       = 18;
	localparam int SPACE_SHIFT = 22;

	// Normalizer datapath.
	localparam int MAG_LIM  = 26;
	localparam int SQ_W     = 54;
	localparam int RAD_W    = 62;
	localparam int RAD_PRE  = 8;
	localparam int ROOT_TOP = 60;
	localparam int ROOT_W   = 31;
	localparam int QPRE     = 19;
	localparam int NUM_W    = 46;
	localparam int DSH_W    = 47;
	localparam int QUO_W    = 16;
	localparam int DCNT_W   = 4;

	localparam logic signed [COMP_W-1:0] ONE_Q14 = 16'sd16384;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [VEC_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [COMP_W-1:0] x;
		logic signed [COMP_W-1:0] y;
		logic signed [COMP_W-1:0] z;
	} comp_vec_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} sum_vec_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_SHIFT,
		U_SQ,
		U_ROOT,
		U_DIV,
		U_DONE
	} unit_state_t;

	typedef enum logic [3:0] {
		T_IDLE,
		T_RD0,
		T_RD1,
		T_RD2,
		T_RD3,
		T_RD4,
		T_SCB,
		T_DIF,
		T_TRI,
		T_TWAIT,
		T_NRM,
		T_NWAIT,
		T_WR,
		T_EMA,
		T_EMB
	} top_state_t;

endpackage

`default_nettype wire

[rtl/core/hns_ram.sv]
// ----------------------------------------------------------------------------
// hns_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_ram #(
	parameter int W = 16,
	parameter int D = 2052
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic                 re,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/hns_unit.sv]
// ----------------------------------------------------------------------------
// hns_unit
// Multi-cycle vector normalizer: prescale, sum of squares, bitwise root,
// three parallel restoring dividers; result in signed Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module hns_unit import hns_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire unit_ctl_t ctl,
	input  wire vec_t      vin,
	output unit_sts_t      sts,
	output comp_vec_t      uout
);

	unit_state_t state_q, state_nxt;

	logic [VEC_W-1:0]  mag_q [3];
	logic              neg_q [3];
	logic [1:0]        sq_idx_q;
	logic [SQ_W-1:0]   acc_q;
	logic [RAD_W-1:0]  x_q, res_q, bit_q;
	logic              zero_q;
	logic [NUM_W-1:0]  num_q [3];
	logic [DSH_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q [3];
	logic [DCNT_W-1:0] dcnt_q;

	logic signed [VEC_W-1:0] vin_a [3];
	logic                    big;
	logic [MAG_LIM-1:0]      sq_sel;
	logic [2*MAG_LIM-1:0]    sq_prod;
	logic [SQ_W-1:0]         acc_nxt;
	logic [RAD_W-1:0]        root_trial, res_nxt;
	logic                    root_ge;
	logic [ROOT_W-1:0]       lq;
	logic                    div_ge [3];
	logic [QUO_W-1:0]        q_sat [3];
	logic signed [COMP_W-1:0] comp [3];

	assign vin_a[0] = vin.x;
	assign vin_a[1] = vin.y;
	assign vin_a[2] = vin.z;

	assign big = (|mag_q[0][VEC_W-1:MAG_LIM]) | (|mag_q[1][VEC_W-1:MAG_LIM]) |
		(|mag_q[2][VEC_W-1:MAG_LIM]);

	always_comb begin
		unique case (sq_idx_q)
			2'd0:    sq_sel = mag_q[0][MAG_LIM-1:0];
			2'd1:    sq_sel = mag_q[1][MAG_LIM-1:0];
			default: sq_sel = mag_q[2][MAG_LIM-1:0];
		endcase
	end

	assign sq_prod    = sq_sel * sq_sel;
	assign acc_nxt    = acc_q + SQ_W'(sq_prod);
	assign root_trial = res_q + bit_q;
	assign root_ge    = x_q >= root_trial;
	assign res_nxt    = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
	assign lq         = res_nxt[ROOT_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_ge[i] = DSH_W'(num_q[i]) >= dsh_q;
			q_sat[i]  = (quo_q[i] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : quo_q[i];
			comp[i]   = neg_q[i] ? -$signed(q_sat[i]) : $signed(q_sat[i]);
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			U_IDLE:  if (ctl.start) state_nxt = U_SHIFT;
			U_SHIFT: if (!big) state_nxt = U_SQ;
			U_SQ:    if (sq_idx_q == 2'd2) state_nxt = (acc_nxt == '0) ? U_DONE : U_ROOT;
			U_ROOT:  if (bit_q == RAD_W'(1)) state_nxt = U_DIV;
			U_DIV:   if (dcnt_q == '0) state_nxt = U_DONE;
			U_DONE:  state_nxt = U_IDLE;
			default: state_nxt = U_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		sts.busy = state_q != U_IDLE;
		sts.done = state_q == U_DONE;
		if (zero_q) begin
			uout.x = '0;
			uout.y = ONE_Q14;
			uout.z = '0;
		end else begin
			uout.x = comp[0];
			uout.y = comp[1];
			uout.z = comp[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (ctl.start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vin_a[i][VEC_W-1];
						mag_q[i] <= vin_a[i][VEC_W-1] ? VEC_W'(-vin_a[i]) : VEC_W'(vin_a[i]);
					end
					sq_idx_q <= '0;
					acc_q    <= '0;
					zero_q   <= 1'b0;
				end
			end
			U_SHIFT: begin
				if (big) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end
			end
			U_SQ: begin
				acc_q    <= acc_nxt;
				sq_idx_q <= sq_idx_q + 2'd1;
				x_q      <= RAD_W'(acc_nxt) << RAD_PRE;
				res_q    <= '0;
				bit_q    <= RAD_W'(1) << ROOT_TOP;
				zero_q   <= acc_nxt == '0;
			end
			U_ROOT: begin
				if (root_ge) x_q <= x_q - root_trial;
				res_q <= res_nxt;
				bit_q <= bit_q >> 2;
				// prepare the dividers on each root step; the last step sets their final values
				for (int i = 0; i < 3; i++) begin
					num_q[i] <= (NUM_W'(mag_q[i][MAG_LIM-1:0]) << QPRE) + NUM_W'(lq);
					quo_q[i] <= '0;
				end
				dsh_q  <= DSH_W'({lq, 1'b0}) << (QUO_W - 1);
				dcnt_q <= DCNT_W'(QUO_W - 1);
			end
			U_DIV: begin
				for (int i = 0; i < 3; i++) begin
					if (div_ge[i]) num_q[i] <= num_q[i] - NUM_W'(dsh_q);
					quo_q[i] <= {quo_q[i][QUO_W-2:0], div_ge[i]};
				end
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/heightfield_normal_stencil_unit.sv]
// A border vertex result bypasses the normalizer; an interior result is set by five
// passes through one shared normalizer (prescale, squares, root, divide and done on
// each pass). One input is taken at a time: the next one waits until the current item
// is finished, and longer while the output register is held.
// Reset: asynchronous, active low; grid_log2 = 8, height_scale = 256, vertex count zero.
// ----------------------------------------------------------------------------
// heightfield_normal_stencil_unit
// Streams a square height grid and emits a unit normal per vertex, with tangent
// and bitangent for interior vertices, from a four-triangle stencil over a two-row store.
// ----------------------------------------------------------------------------
`default_nettype none

module heightfield_normal_stencil_unit import hns_pkg::*; #(
	parameter int MAX_GRID_LOG2 = MAX_GRID_LOG2_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration writes
	input  wire logic                        wr_en,
	input  wire logic [CFG_IDX_W-1:0]        wr_index,
	input  wire logic [CFG_DATA_W-1:0]       wr_data,
	// height samples
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [HEIGHT_W-1:0]  height,
	// vertex results
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [VIDX_W-1:0]                vertex_index,
	output logic signed [COMP_W-1:0]         normal_x,
	output logic signed [COMP_W-1:0]         normal_y,
	output logic signed [COMP_W-1:0]         normal_z,
	output logic signed [COMP_W-1:0]         tangent_x,
	output logic signed [COMP_W-1:0]         tangent_y,
	output logic signed [COMP_W-1:0]         tangent_z,
	output logic signed [COMP_W-1:0]         bitangent_x,
	output logic signed [COMP_W-1:0]         bitangent_y,
	output logic signed [COMP_W-1:0]         bitangent_z,
	output logic                             is_interior,
	output logic                             last_of_run
);

`include "heightfield_normal_stencil_unit_assert.svh"

	// Row/column positions reach 2^MAX_GRID_LOG2; each bank of the line store
	// holds one row plus slack. The store is not cleared; the raster order never
	// reads an entry before it is written.
	localparam int CW       = MAX_GRID_LOG2 + 1;
	localparam int ROW_SLOT = (1 << MAX_GRID_LOG2) + 2;
	localparam int DEPTH    = 2 * ROW_SLOT;
	localparam int AW       = $clog2(DEPTH);

	// ---------------- configuration and raster position ----------------
	logic [GRID_W-1:0]  grid_q;
	logic [SCALE_W-1:0] scale_q;
	logic [VIDX_W-1:0]  n_q;
	logic [CW-1:0]      row_q, col_q;

	logic [GRID_W-1:0]  g_eff;
	logic [CW-1:0]      w_m1, w_full;
	logic               acc_in, inside_nxt;

	// Clamp the grid size into the supported range.
	always_comb begin
		if (grid_q == '0) begin
			g_eff = GRID_W'(1);
		end else if (grid_q > GRID_W'(MAX_GRID_LOG2)) begin
			g_eff = GRID_W'(MAX_GRID_LOG2);
		end else begin
			g_eff = grid_q;
		end
	end

	assign w_m1   = CW'(1) << g_eff;
	assign w_full = w_m1 + CW'(1);
	assign acc_in = in_valid & in_ready;

	// Interior: the vertex one row up is off the top, bottom, left and right edges.
	assign inside_nxt = (row_q >= CW'(2)) && (col_q != '0) && (col_q < w_m1);

	// ---------------- item registers ----------------
	top_state_t state_q, state_nxt;

	logic [VIDX_W-1:0]          item_n_q;
	logic [CW-1:0]              item_row_q, item_col_q;
	logic signed [HEIGHT_W-1:0] cur_q;
	logic                       has_a_q, has_b_q, inside_q;
	logic [1:0]                 tri_q;

	logic signed [SCALED_W-1:0] yc_q, yl_q, yr_q, yt_q, yb_q;
	logic signed [DIFF_W-1:0]   dl_q, ndr_q, dt_q, ndb_q;
	sum_vec_t                   sum_q;
	comp_vec_t                  nrm_q;

	// ---------------- line store ----------------
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_raddr, addr_c, addr_l, addr_r, addr_t;
	logic [AW-1:0]       base_v, base_t;
	logic [HEIGHT_W-1:0] ram_rdata;

	// The vertex row sits in the bank opposite the incoming row; the row above
	// it shares the incoming row's bank and is overwritten after its read.
	assign base_v = item_row_q[0] ? '0 : AW'(ROW_SLOT);
	assign base_t = item_row_q[0] ? AW'(ROW_SLOT) : '0;
	assign addr_c = base_v + AW'(item_col_q);
	assign addr_l = base_v + AW'(item_col_q - CW'(1));
	assign addr_r = base_v + AW'(item_col_q + CW'(1));
	assign addr_t = base_t + AW'(item_col_q);

	always_comb begin
		unique case (state_q)
			T_RD1:   ram_raddr = addr_l;
			T_RD2:   ram_raddr = addr_r;
			T_RD3:   ram_raddr = addr_t;
			default: ram_raddr = addr_c;
		endcase
	end

	hns_ram #(
		.W (HEIGHT_W),
		.D (DEPTH)
	) u_row_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_t),
		.wdata (cur_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------- scaling ----------------
	// One shared multiplier scales each sample as it leaves the store; the
	// fresh sample from below goes through it once the reads are done.
	logic signed [HEIGHT_W-1:0]  mul_h;
	logic signed [SCALED_W:0]    mul_full;
	logic signed [SCALED_W-1:0]  scaled;

	assign mul_h    = (state_q == T_SCB) ? cur_q : $signed(ram_rdata);
	assign mul_full = mul_h * $signed({1'b0, scale_q});
	assign scaled   = mul_full[SCALED_W-1:0];

	// ---------------- normalizer ----------------
	unit_ctl_t          unit_ctl;
	unit_sts_t          unit_sts;
	vec_t               unit_vin, tri_vec;
	comp_vec_t          unit_out;
	logic signed [VEC_W-1:0] spacing;

	// Vertex spacing 2^-g in units of 2^-22.
	assign spacing = VEC_W'(1) << (5'(SPACE_SHIFT) - {1'b0, g_eff});

	// Triangle normals (C,L,T), (C,T,R), (C,R,B), (C,B,L) up to a positive factor.
	always_comb begin
		tri_vec.x = (tri_q[1] == 1'b0) ? VEC_W'(dt_q) : VEC_W'(ndb_q);
		tri_vec.y = spacing;
		tri_vec.z = ((tri_q == 2'd0) || (tri_q == 2'd3)) ? VEC_W'(dl_q) : VEC_W'(ndr_q);
	end

	always_comb begin
		if (state_q == T_NRM) begin
			unit_vin.x = VEC_W'(sum_q.x);
			unit_vin.y = VEC_W'(sum_q.y);
			unit_vin.z = VEC_W'(sum_q.z);
		end else begin
			unit_vin = tri_vec;
		end
	end

	hns_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (unit_ctl),
		.vin    (unit_vin),
		.sts    (unit_sts),
		.uout   (unit_out)
	);

	// ---------------- control ----------------
	logic out_free, load_a, load_b;

	assign out_free = !out_valid || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			T_IDLE:  if (acc_in) state_nxt = inside_nxt ? T_RD0 : T_WR;
			T_RD0:   state_nxt = T_RD1;
			T_RD1:   state_nxt = T_RD2;
			T_RD2:   state_nxt = T_RD3;
			T_RD3:   state_nxt = T_RD4;
			T_RD4:   state_nxt = T_SCB;
			T_SCB:   state_nxt = T_DIF;
			T_DIF:   state_nxt = T_TRI;
			T_TRI:   state_nxt = T_TWAIT;
			T_TWAIT: if (unit_sts.done) state_nxt = (tri_q == 2'd3) ? T_NRM : T_TRI;
			T_NRM:   state_nxt = T_NWAIT;
			T_NWAIT: if (unit_sts.done) state_nxt = T_EMA;
			T_WR:    state_nxt = has_a_q ? T_EMA : T_IDLE;
			T_EMA:   if (out_free) state_nxt = has_b_q ? T_EMB : T_IDLE;
			T_EMB:   if (out_free) state_nxt = T_IDLE;
			default: state_nxt = T_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = state_q == T_IDLE;
		ram_re         = (state_q == T_RD0) || (state_q == T_RD1) ||
			(state_q == T_RD2) || (state_q == T_RD3);
		ram_we         = (state_q == T_RD4) || (state_q == T_WR);
		unit_ctl.start = (state_q == T_TRI) || (state_q == T_NRM);
		load_a         = (state_q == T_EMA) && out_free;
		load_b         = (state_q == T_EMB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			grid_q  <= GRID_RESET;
			scale_q <= SCALE_RESET;
			n_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				unique case (wr_index)
					REG_GRID_LOG2: begin
						// new grid size: restart the raster
						grid_q <= wr_data[GRID_W-1:0];
						n_q    <= '0;
						row_q  <= '0;
						col_q  <= '0;
					end
					REG_HEIGHT_SCALE: scale_q <= wr_data[SCALE_W-1:0];
					default: begin
					end
				endcase
			end else if (acc_in) begin
				// advance the raster position, wrap after the last vertex
				if (col_q == w_m1) begin
					col_q <= '0;
					if (row_q == w_m1) begin
						row_q <= '0;
						n_q   <= '0;
					end else begin
						row_q <= row_q + CW'(1);
						n_q   <= n_q + VIDX_W'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
					n_q   <= n_q + VIDX_W'(1);
				end
			end
		end
	end

	// Per-item datapath: capture the transaction, gather the stencil, accumulate.
	always_ff @(posedge clk) begin
		if (acc_in) begin
			item_n_q   <= n_q;
			item_row_q <= row_q;
			item_col_q <= col_q;
			cur_q      <= height;
			has_a_q    <= row_q != '0;
			has_b_q    <= row_q == w_m1;
			inside_q   <= inside_nxt;
		end
		unique case (state_q)
			T_RD1: yc_q <= scaled;
			T_RD2: yl_q <= scaled;
			T_RD3: yr_q <= scaled;
			T_RD4: yt_q <= scaled;
			T_SCB: yb_q <= scaled;
			T_DIF: begin
				dl_q  <= DIFF_W'(yl_q) - DIFF_W'(yc_q);
				ndr_q <= DIFF_W'(yc_q) - DIFF_W'(yr_q);
				dt_q  <= DIFF_W'(yt_q) - DIFF_W'(yc_q);
				ndb_q <= DIFF_W'(yc_q) - DIFF_W'(yb_q);
				sum_q <= '0;
				tri_q <= '0;
			end
			T_TWAIT: begin
				if (unit_sts.done) begin
					sum_q.x <= sum_q.x + SUM_W'(unit_out.x);
					sum_q.y <= sum_q.y + SUM_W'(unit_out.y);
					sum_q.z <= sum_q.z + SUM_W'(unit_out.z);
					tri_q   <= tri_q + 2'd1;
				end
			end
			T_NWAIT: begin
				if (unit_sts.done) nrm_q <= unit_out;
			end
			default: begin
			end
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_a || load_b) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_a && inside_q) begin
			// vertex one row up, stencil result
			vertex_index <= item_n_q - VIDX_W'(w_full);
			normal_x     <= nrm_q.x;
			normal_y     <= nrm_q.y;
			normal_z     <= nrm_q.z;
			tangent_x    <= nrm_q.y;
			tangent_y    <= -nrm_q.x;
			tangent_z    <= -nrm_q.z;
			bitangent_x  <= -nrm_q.x;
			bitangent_y  <= -nrm_q.z;
			bitangent_z  <= nrm_q.y;
			is_interior  <= 1'b1;
			last_of_run  <= !has_b_q;
		end else if (load_a || load_b) begin
			// border vertex: straight up, no tangent frame
			vertex_index <= load_a ? (item_n_q - VIDX_W'(w_full)) : item_n_q;
			normal_x     <= '0;
			normal_y     <= ONE_Q14;
			normal_z     <= '0;
			tangent_x    <= '0;
			tangent_y    <= '0;
			tangent_z    <= '0;
			bitangent_x  <= '0;
			bitangent_y  <= '0;
			bitangent_z  <= '0;
			is_interior  <= 1'b0;
			last_of_run  <= load_b || !has_b_q;
		end
	end

	// ---------------- assertions ----------------
	`HNS_ASSERT_IMPL(a_unit_start_idle, clk, arst_n, unit_ctl.start, !unit_sts.busy)
	`HNS_ASSERT_IMPL(a_store_port, clk, arst_n, ram_we, !ram_re)
	`HNS_ASSERT_IMPL(a_pos_range, clk, arst_n, 1'b1, (col_q <= w_m1) && (row_q <= w_m1))
	`HNS_ASSERT_NEXT(a_second_last, clk, arst_n, load_b, out_valid && last_of_run)

endmodule

`default_nettype wire
